[hw/rtl/lkvc_pkg.sv]
// Shared constants, types and helpers for the LRU key-value cache.
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int DATA_W  = 32;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             is_get;
		logic [OCC_W-1:0] occupancy;
	} ctrl_sts_t;

	// lowest set bit; zero when none
	function automatic logic [IDX_W-1:0] first_one(input logic [ENTRIES-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

[hw/rtl/lru_key_value_cache.sv]
// Top level of the LRU key-value cache: APB register, sequencer and datapath.
//
// A fully associative 16-entry key-value store with least-recently-used
// replacement. A request is taken on a clock edge with start high and busy
// low; busy then stays high through the lookup and commit states, so a new
// request is taken only once the last one is through. The lookup state matches
// the key against all entries and finds the oldest and a free slot; the commit
// state updates the table and ranks. A get returns its transaction in the first
// cycle with busy low again, for exactly one cycle with done high: hit and
// read_value (zero on a miss). The receiver cannot hold it off, so sample it
// then. A put gives no result. The capacity register (byte address 0, reset
// 16) limits how many entries are used before eviction; 0 acts as 1 and
// values above 16 act as 16. Lowering it flushes nothing: each later new key
// evicts one entry. Write it only while the block is idle.
module lru_key_value_cache (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// requests
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 opcode,
	input  logic signed [lkvc_pkg::DATA_W-1:0]   lookup_key,
	input  logic signed [lkvc_pkg::DATA_W-1:0]   store_value,
	// results
	output logic                                 done,
	output logic                                 hit,
	output logic signed [lkvc_pkg::DATA_W-1:0]   read_value,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lkvc_pkg::PADDR_W-1:0]         paddr,
	input  logic [lkvc_pkg::APB_W-1:0]           pwdata,
	output logic [lkvc_pkg::APB_W-1:0]           prdata,
	output logic                                 pready
);
	import lkvc_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	ctrl_cmd_t        cmd;
	ctrl_sts_t        sts;
	logic             cfg_wr;

	// APB: zero wait states, word select on paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_W'(capacity_q) : '0;

	lkvc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lkvc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.capacity    (capacity_q),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value)
	);

	// a result only follows a commit, so the block was busy the cycle before
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result transaction without a request in flight");

	// an accepted request keeps the block busy through lookup and commit
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 busy)
		else $error("accepted request did not hold busy");

	// occupancy never exceeds the table size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.occupancy <= OCC_W'(ENTRIES))
		else $error("occupancy beyond table size");

	// a miss never returns data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (read_value == '0))
		else $error("miss returned non-zero data");

endmodule

[hw/rtl/lkvc_ctrl.sv]
// Sequencer for the LRU key-value cache: accept, look up, commit.
module lkvc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lkvc_pkg::ctrl_sts_t   sts,
	output lkvc_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);
	import lkvc_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.lookup  = (state_q == ST_LOOKUP);
	assign cmd.commit  = (state_q == ST_COMMIT);
	assign cmd.emit    = (state_q == ST_COMMIT) && sts.is_get;

endmodule

[hw/rtl/lkvc_datapath.sv]
// Entry table, parallel key match, recency ranks and result register.
module lkvc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkvc_pkg::ctrl_cmd_t           cmd,
	output lkvc_pkg::ctrl_sts_t           sts,
	input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
	input  logic                          opcode,
	input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
	input  logic signed [lkvc_pkg::DATA_W-1:0] store_value,
	output logic                          done,
	output logic                          hit,
	output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);
	import lkvc_pkg::*;

	// request registers
	logic              req_op_q;
	logic [DATA_W-1:0] req_key_q;
	logic [DATA_W-1:0] req_val_q;

	// table
	logic [DATA_W-1:0] keys_q [ENTRIES];
	logic [DATA_W-1:0] vals_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0] rank_q [ENTRIES];
	logic [OCC_W-1:0]  occ_q;

	// lookup stage
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] oldest;
	logic [ENTRIES-1:0] evict_mask;
	logic [ENTRIES-1:0] valid_after;
	logic [CMP_W-1:0]   eff_cap;
	logic [OCC_W-1:0]   occ_m1;
	logic               need_evict;

	logic               hit_s1;
	logic [IDX_W-1:0]   hit_idx_s1;
	logic               evict_s1;
	logic [ENTRIES-1:0] evict_mask_s1;
	logic [IDX_W-1:0]   free_idx_s1;

	// result
	logic              done_q;
	logic              hit_q;
	logic [DATA_W-1:0] read_value_q;
	logic [RANK_W-1:0] hit_rank;

	assign occ_m1 = occ_q - OCC_W'(1);

	always_comb begin
		if (capacity == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(capacity);
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (keys_q[i] == req_key_q);
			// ranks are dense, so the oldest holds occupancy-1
			oldest[i] = valid_q[i] && (OCC_W'(rank_q[i]) == occ_m1);
		end
	end

	assign need_evict  = !(|match) && (CMP_W'(occ_q) >= eff_cap);
	assign evict_mask  = need_evict ? oldest : '0;
	assign valid_after = valid_q & ~evict_mask;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q  <= opcode;
			req_key_q <= lookup_key;
			req_val_q <= store_value;
		end
		if (cmd.lookup) begin
			hit_s1        <= |match;
			hit_idx_s1    <= first_one(match);
			evict_s1      <= need_evict;
			evict_mask_s1 <= evict_mask;
			free_idx_s1   <= first_one(~valid_after);
		end
	end

	assign hit_rank = rank_q[hit_idx_s1];

	// table update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (hit_s1) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == hit_idx_s1) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end else if (req_op_q == OP_PUT) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == free_idx_s1) begin
						rank_q[i] <= '0;
					end else if (evict_mask_s1[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
				valid_q <= (valid_q & ~evict_mask_s1)
					| (ENTRIES'(1) << free_idx_s1);
				occ_q   <= occ_q - OCC_W'(evict_s1) + OCC_W'(1);
			end
		end
	end

	// keys and values carry no reset: only valid entries are ever read
	always_ff @(posedge clk) begin
		if (cmd.commit && (req_op_q == OP_PUT)) begin
			if (hit_s1) begin
				vals_q[hit_idx_s1] <= req_val_q;
			end else begin
				keys_q[free_idx_s1] <= req_key_q;
				vals_q[free_idx_s1] <= req_val_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit_q        <= hit_s1;
			read_value_q <= hit_s1 ? vals_q[hit_idx_s1] : '0;
		end
	end

	assign sts.is_get    = (req_op_q == OP_GET);
	assign sts.occupancy = occ_q;

	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule
